@@ sv/assert_macros.svh @@
// Assertion macros shared by the deadline timer queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

@@ sv/dtq_pkg.sv @@
// Shared constants, result codes and command types of the deadline timer queue.
package dtq_pkg;
   localparam int QUEUE_DEPTH  = 32;
   localparam int TASK_ID_BITS = 8;
   localparam int ID_FIELD_W   = 8;
   localparam int STORE_ID_W   = (TASK_ID_BITS < ID_FIELD_W) ? TASK_ID_BITS : ID_FIELD_W;
   localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W        = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      KIND_NEW_EARLIEST = 3'd0,
      KIND_INSERTED     = 3'd1,
      KIND_PASSED       = 3'd2,
      KIND_FULL         = 3'd3,
      KIND_RELEASED     = 3'd4,
      KIND_NONE         = 3'd5
   } kind_type;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_EXPIRE = 1'b1;

   typedef struct packed {
      logic latch;
      logic insert;
      logic release_head;
      logic none_due;
   } cmd_type;

   typedef struct packed {
      logic is_expire;
      logic head_due;
      logic more_due;
   } status_type;

   // True when time a is strictly earlier than time b.
   function automatic logic earlier(input logic [31:0] as, input logic [29:0] an,
                                    input logic [31:0] bs, input logic [29:0] bn);
      earlier = (as != bs) ? (as < bs) : (an < bn);
   endfunction
endpackage

@@ sv/dtq_ctrl.sv @@
// Controller state machine of the deadline timer queue.
`include "assert_macros.svh"
module dtq_ctrl import dtq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               if (!status.is_expire) begin
                  cmd.insert = 1'b1;
                  state_in   = ST_IDLE;
               end else if (status.head_due) begin
                  cmd.release_head = 1'b1;
                  if (!status.more_due) state_in = ST_IDLE;
               end else begin
                  cmd.none_due = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.insert || cmd.release_head || cmd.none_due) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_insert_done, clock, reset,
                state_ff == ST_EXEC && out_free && !status.is_expire,
                state_ff == ST_IDLE && rsp_valid_ff)
   `ASSERT_IMPLIES(a_one_cmd, clock, reset, 1'b1,
                   $onehot0({cmd.latch, cmd.insert, cmd.release_head, cmd.none_due}))
endmodule

@@ sv/dtq_datapath.sv @@
// Datapath of the deadline timer queue: latched item, sorted cell chain, result register.
`include "assert_macros.svh"
module dtq_datapath import dtq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  req_func,
   input  logic [ID_FIELD_W-1:0] req_task_id,
   input  logic [31:0]           req_deadline_sec,
   input  logic [29:0]           req_deadline_nsec,
   input  logic [31:0]           req_now_sec,
   input  logic [29:0]           req_now_nsec,
   output logic [2:0]            rsp_kind,
   output logic [ID_FIELD_W-1:0] rsp_released_id,
   output logic                  rsp_last
);
   logic                  func_ff;
   logic [STORE_ID_W-1:0] id_ff;
   logic [31:0]           ds_ff, ns_ff;
   logic [29:0]           dn_ff, nn_ff;

   logic [31:0]           sec_ff  [QUEUE_DEPTH];
   logic [29:0]           nsec_ff [QUEUE_DEPTH];
   logic [STORE_ID_W-1:0] task_ff [QUEUE_DEPTH];
   logic [COUNT_W-1:0]    count_ff;

   kind_type              kind_ff;
   logic [ID_FIELD_W-1:0] rid_ff;
   logic                  last_ff;

   logic [QUEUE_DEPTH-1:0] gt;
   logic                   passed, full;
   logic [ID_FIELD_W-1:0]  id_ext, head_ext;

   // A cell moves back when the new deadline is earlier or the cell is unused.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         gt[i] = earlier(ds_ff, dn_ff, sec_ff[i], nsec_ff[i]) ||
                 (COUNT_W'(i) >= count_ff);
      end
      passed = !earlier(ns_ff, nn_ff, ds_ff, dn_ff);
      full   = (count_ff == COUNT_W'(QUEUE_DEPTH));
      status.is_expire = (func_ff == FUNC_EXPIRE);
      status.head_due  = (count_ff != '0) && !earlier(ns_ff, nn_ff, sec_ff[0], nsec_ff[0]);
      status.more_due  = (count_ff > COUNT_W'(1)) &&
                         !earlier(ns_ff, nn_ff, sec_ff[1], nsec_ff[1]);
      id_ext   = '0;
      id_ext[STORE_ID_W-1:0] = id_ff;
      head_ext = '0;
      head_ext[STORE_ID_W-1:0] = task_ff[0];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff <= req_func;
         id_ff   <= req_task_id[STORE_ID_W-1:0];
         ds_ff   <= req_deadline_sec;
         dn_ff   <= req_deadline_nsec;
         ns_ff   <= req_now_sec;
         nn_ff   <= req_now_nsec;
      end
      if (cmd.insert) begin
         rid_ff  <= id_ext;
         last_ff <= 1'b1;
         if (passed)      kind_ff <= KIND_PASSED;
         else if (full)   kind_ff <= KIND_FULL;
         else if (gt[0])  kind_ff <= KIND_NEW_EARLIEST;
         else             kind_ff <= KIND_INSERTED;
         if (!passed && !full) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (gt[i]) begin
                  if (i == 0 || !gt[(i == 0) ? 0 : i - 1]) begin
                     sec_ff[i]  <= ds_ff;
                     nsec_ff[i] <= dn_ff;
                     task_ff[i] <= id_ff;
                  end else begin
                     sec_ff[i]  <= sec_ff[(i == 0) ? 0 : i - 1];
                     nsec_ff[i] <= nsec_ff[(i == 0) ? 0 : i - 1];
                     task_ff[i] <= task_ff[(i == 0) ? 0 : i - 1];
                  end
               end
            end
         end
      end
      if (cmd.release_head) begin
         kind_ff <= KIND_RELEASED;
         rid_ff  <= head_ext;
         last_ff <= !status.more_due;
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            sec_ff[i]  <= sec_ff[i + 1];
            nsec_ff[i] <= nsec_ff[i + 1];
            task_ff[i] <= task_ff[i + 1];
         end
      end
      if (cmd.none_due) begin
         kind_ff <= KIND_NONE;
         rid_ff  <= '0;
         last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.insert && !passed && !full) begin
         count_ff <= count_ff + COUNT_W'(1);
      end else if (cmd.release_head) begin
         count_ff <= count_ff - COUNT_W'(1);
      end
   end

   assign rsp_kind        = kind_ff;
   assign rsp_released_id = rid_ff;
   assign rsp_last        = last_ff;

   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_W'(QUEUE_DEPTH))
   `ASSERT_NEXT(a_release_count, clock, reset, cmd.release_head,
                count_ff == $past(count_ff) - COUNT_W'(1))
endmodule

@@ sv/deadline_timer_queue_unit.sv @@
// Top level of the deadline timer queue: controller and datapath.
// The req_ channel carries one item: an insert (req_func 0) with a task id,
// a deadline and the current time, or an expire (req_func 1) with the time.
// The rsp_ channel returns result transfers: kind, task id and a last flag.
// Entries sit in a sorted chain of register cells, earliest at cell 0.
// An insert compares its deadline against every cell at once and, unless it has
// passed or the queue is full, shifts the later cells back and stores the item.
// An expire releases one due head cell per cycle while the output register is
// free; with no due entry it answers "none due".
// The next item can be taken in the cycle after the last result of an item is
// loaded into the output register; one item is at work at a time.
// The output register lets a new item be taken while a result still waits.
// When the receiver stalls, the result holds and work waits for it.
// Reset empties the queue at once (the entry count clears); cell contents
// are not cleared.
module deadline_timer_queue_unit import dtq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [ID_FIELD_W-1:0] req_task_id,
   input  logic [31:0]           req_deadline_sec,
   input  logic [29:0]           req_deadline_nsec,
   input  logic [31:0]           req_now_sec,
   input  logic [29:0]           req_now_nsec,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_kind,
   output logic [ID_FIELD_W-1:0] rsp_released_id,
   output logic                  rsp_last
);
   cmd_type    cmd;
   status_type status;

   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dtq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_func),
      .req_task_id       (req_task_id),
      .req_deadline_sec  (req_deadline_sec),
      .req_deadline_nsec (req_deadline_nsec),
      .req_now_sec       (req_now_sec),
      .req_now_nsec      (req_now_nsec),
      .rsp_kind          (rsp_kind),
      .rsp_released_id   (rsp_released_id),
      .rsp_last          (rsp_last)
   );
endmodule
